/* design/aabb_pkg.sv */
`default_nettype none

package aabb_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int CFG_WIDTH       = 16;

	typedef logic [1:0] opcode_t;
	typedef logic [1:0] shape_t;

	localparam opcode_t OP_CLEAR     = 2'd0;
	localparam opcode_t OP_ADD_POINT = 2'd1;
	localparam opcode_t OP_ADD_BOX   = 2'd2;
	localparam opcode_t OP_EXTEND_Z  = 2'd3;

	localparam shape_t SHAPE_EMPTY  = 2'd0;
	localparam shape_t SHAPE_SOLID  = 2'd1;
	localparam shape_t SHAPE_FLAT   = 2'd2;
	localparam shape_t SHAPE_SINGLE = 2'd3;

endpackage

`default_nettype wire

/* design/aabb_sumsq.sv */
`default_nettype none

// Sum of squared extents over three axes, one half-width partial product
// per cycle on a single shared multiplier (four per axis).
module aabb_sumsq #(
	parameter int COORD_WIDTH = aabb_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic signed [COORD_WIDTH-1:0] lower [3],
	input  wire logic signed [COORD_WIDTH-1:0] upper [3],
	output logic                               done,
	output logic [2*COORD_WIDTH+1:0]           sum
);

	localparam int W     = COORD_WIDTH;
	localparam int H     = (W + 1) / 2;
	localparam int EW    = 2 * H;
	localparam int SW    = 2 * W + 2;
	localparam int STEPS = 12;

	logic [EW-1:0] ext_q [3];
	logic [3:0]    step_q;
	logic          run_q;
	logic [EW-1:0] prod_s1;
	logic [1:0]    part_s1;
	logic          pvld_s1;
	logic          last_s1;
	logic [SW-1:0] acc_q;
	logic          done_q;

	logic [W:0]    diff [3];
	logic [W:0]    mag [3];
	logic [EW-1:0] e_sel;
	logic [H-1:0]  op_a;
	logic [H-1:0]  op_b;
	logic [SW-1:0] prod_ext;
	logic [SW-1:0] prod_sh;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			diff[a] = {upper[a][W-1], upper[a]} - {lower[a][W-1], lower[a]};
			mag[a]  = diff[a][W] ? (~diff[a] + (W+1)'(1)) : diff[a];
		end
	end

	assign e_sel = ext_q[step_q[3:2]];
	assign op_a  = step_q[0] ? e_sel[EW-1:H] : e_sel[H-1:0];
	assign op_b  = step_q[1] ? e_sel[EW-1:H] : e_sel[H-1:0];

	assign prod_ext = SW'(prod_s1);
	always_comb begin
		case (part_s1)
			2'd0:    prod_sh = prod_ext;
			2'd3:    prod_sh = prod_ext << (2 * H);
			default: prod_sh = prod_ext << H;
		endcase
	end

	always_ff @(posedge clk) begin
		if (start) begin
			for (int a = 0; a < 3; a++) begin
				ext_q[a] <= EW'(mag[a][W-1:0]);
			end
		end
		prod_s1 <= op_a * op_b;
		part_s1 <= step_q[1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= '0;
			run_q   <= 1'b0;
			pvld_s1 <= 1'b0;
			last_s1 <= 1'b0;
			acc_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			pvld_s1 <= run_q;
			last_s1 <= run_q && (step_q == 4'(STEPS - 1));
			done_q  <= pvld_s1 && last_s1;
			if (start) begin
				step_q <= '0;
				run_q  <= 1'b1;
				acc_q  <= '0;
			end else begin
				if (run_q) begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'(STEPS - 1)) begin
						run_q <= 1'b0;
					end
				end
				if (pvld_s1) begin
					acc_q <= acc_q + prod_sh;
				end
			end
		end
	end

	assign done = done_q;
	assign sum  = acc_q;

endmodule

`default_nettype wire

/* design/aabb_isqrt.sv */
`default_nettype none

// Floor square root, restoring, two radicand bits per cycle.
module aabb_isqrt #(
	parameter int COORD_WIDTH = aabb_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [2*COORD_WIDTH+1:0]     radicand,
	output logic                              done,
	output logic [COORD_WIDTH:0]              root
);

	localparam int W   = COORD_WIDTH;
	localparam int SW  = 2 * W + 2;
	localparam int RW  = W + 3;
	localparam int NIT = W + 1;
	localparam int CW  = $clog2(NIT);

	logic [SW-1:0] rad_q;
	logic [RW-1:0] rem_q;
	logic [W:0]    root_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;

	logic [RW-1:0] rem_sh;
	logic [RW-1:0] trial;
	logic          ge;

	assign rem_sh = {rem_q[RW-3:0], rad_q[SW-1:SW-2]};
	assign trial  = {root_q, 2'b01};
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= ge ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[W-1:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(NIT - 1);
				run_q <= 1'b1;
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CW'(1);
				end
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

`default_nettype wire

/* design/aabb_accumulator_3d.sv */
// Running 3D axis-aligned bounding box, Q16.16 coordinates.
// Input channel: in_valid / in_stall with opcode (clear, add point, add box,
// extend max z), two corner points and box_valid. A word is taken when
// in_valid is high and in_stall low. Output channel: out_valid / out_stall;
// every input word gives exactly one result word with the bounds, the stored
// center and diagonal, valid_res and shape_class.
// min_diagonal is written through cfg_write_en / cfg_write_data; the user
// must write it only while idle, the block does not enforce this.
// Items that change a non-empty box run 12 partial products on the shared
// half-width multiplier, then COORD_WIDTH + 1 steps of the bit-serial
// square root; add box first passes a corner state for the stored corner.
// Clear, ignored add box and extend on an empty box go straight to output.
// New words stall until the result is loaded into the output register.
// The output register frees the datapath: a new word is accepted while a
// result waits on out_stall; a second result waits in the sequencer.
// Reset: box empty, center, diagonal and valid cleared, min_diagonal 0,
// no result pending.
`default_nettype none

module aabb_accumulator_3d #(
	parameter int COORD_WIDTH = aabb_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_write_en,
	input  wire logic [aabb_pkg::CFG_WIDTH-1:0]   cfg_write_data,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire aabb_pkg::opcode_t                opcode,
	input  wire logic signed [COORD_WIDTH-1:0]    point_x,
	input  wire logic signed [COORD_WIDTH-1:0]    point_y,
	input  wire logic signed [COORD_WIDTH-1:0]    point_z,
	input  wire logic signed [COORD_WIDTH-1:0]    other_x,
	input  wire logic signed [COORD_WIDTH-1:0]    other_y,
	input  wire logic signed [COORD_WIDTH-1:0]    other_z,
	input  wire logic                             box_valid,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic signed [COORD_WIDTH-1:0]         min_x,
	output logic signed [COORD_WIDTH-1:0]         min_y,
	output logic signed [COORD_WIDTH-1:0]         min_z,
	output logic signed [COORD_WIDTH-1:0]         max_x,
	output logic signed [COORD_WIDTH-1:0]         max_y,
	output logic signed [COORD_WIDTH-1:0]         max_z,
	output logic signed [COORD_WIDTH-1:0]         center_x,
	output logic signed [COORD_WIDTH-1:0]         center_y,
	output logic signed [COORD_WIDTH-1:0]         center_z,
	output logic [COORD_WIDTH+1:0]                diagonal,
	output logic                                  valid_res,
	output aabb_pkg::shape_t                      shape_class
);

	localparam int W    = COORD_WIDTH;
	localparam int DW   = W + 2;
	localparam int SW   = 2 * W + 2;
	localparam int CMPW = (DW > aabb_pkg::CFG_WIDTH) ? DW : aabb_pkg::CFG_WIDTH;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CORNER = 3'd1;
	localparam logic [2:0] ST_START  = 3'd2;
	localparam logic [2:0] ST_SQ     = 3'd3;
	localparam logic [2:0] ST_RT     = 3'd4;
	localparam logic [2:0] ST_OUT    = 3'd5;

	localparam logic signed [W-1:0] COORD_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] COORD_MIN = {1'b1, {(W-1){1'b0}}};

	logic [2:0]                  state_q;
	logic [2:0]                  state_d;
	logic [aabb_pkg::CFG_WIDTH-1:0] min_diag_q;

	logic signed [W-1:0] lo_q [3];
	logic signed [W-1:0] up_q [3];
	logic signed [W-1:0] oth_q [3];
	logic signed [W-1:0] center_q [3];
	logic [DW-1:0]       diag_q;
	logic                valid_q;
	logic                empty_q;

	logic signed [W-1:0] out_lo_q [3];
	logic signed [W-1:0] out_up_q [3];
	logic signed [W-1:0] out_ctr_q [3];
	logic [DW-1:0]       out_diag_q;
	logic                out_vres_q;
	aabb_pkg::shape_t    out_shape_q;
	logic                out_valid_q;

	logic                accept;
	logic                do_add;
	logic                do_ext;
	logic                do_clear;
	logic                do_eval;
	logic                out_load;
	logic signed [W-1:0] pin [3];
	logic signed [W-1:0] pt [3];
	logic signed [W-1:0] nlo [3];
	logic signed [W-1:0] nup [3];
	logic [W:0]          zsum;
	logic signed [W-1:0] zsat;
	logic [W:0]          csum [3];
	logic [2:0]          flat;
	aabb_pkg::shape_t    shape;

	logic                sum_done;
	logic [SW-1:0]       sum;
	logic                rt_done;
	logic [W:0]          root;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign do_clear = accept && (opcode == aabb_pkg::OP_CLEAR);
	assign do_add   = (accept && ((opcode == aabb_pkg::OP_ADD_POINT) ||
	                  ((opcode == aabb_pkg::OP_ADD_BOX) && box_valid))) ||
	                  (state_q == ST_CORNER);
	assign do_ext   = accept && (opcode == aabb_pkg::OP_EXTEND_Z) && !empty_q;
	assign do_eval  = (state_q == ST_RT) && rt_done;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	assign pin[0] = point_x;
	assign pin[1] = point_y;
	assign pin[2] = point_z;

	// box add merges the max corner first, then the stored min corner
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			pt[a]  = (state_q == ST_CORNER) ? oth_q[a] : pin[a];
			nlo[a] = (empty_q || (pt[a] < lo_q[a])) ? pt[a] : lo_q[a];
			nup[a] = (empty_q || (pt[a] > up_q[a])) ? pt[a] : up_q[a];
			csum[a] = {lo_q[a][W-1], lo_q[a]} + {up_q[a][W-1], up_q[a]};
			flat[a] = (lo_q[a] == up_q[a]);
		end
	end

	assign zsum = {up_q[2][W-1], up_q[2]} + {point_z[W-1], point_z};
	assign zsat = (zsum[W] == zsum[W-1]) ? zsum[W-1:0] :
	              (zsum[W] ? COORD_MIN : COORD_MAX);

	always_comb begin
		if (empty_q) begin
			shape = aabb_pkg::SHAPE_EMPTY;
		end else if (&flat) begin
			shape = aabb_pkg::SHAPE_SINGLE;
		end else if (|flat) begin
			shape = aabb_pkg::SHAPE_FLAT;
		end else begin
			shape = aabb_pkg::SHAPE_SOLID;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (opcode)
						aabb_pkg::OP_ADD_POINT: state_d = ST_START;
						aabb_pkg::OP_ADD_BOX:   state_d = box_valid ? ST_CORNER : ST_OUT;
						aabb_pkg::OP_EXTEND_Z:  state_d = empty_q ? ST_OUT : ST_START;
						default:                state_d = ST_OUT;
					endcase
				end
			end
			ST_CORNER: state_d = ST_START;
			ST_START:  state_d = ST_SQ;
			ST_SQ: begin
				if (sum_done) state_d = ST_RT;
			end
			ST_RT: begin
				if (rt_done) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			min_diag_q  <= '0;
			empty_q     <= 1'b1;
			valid_q     <= 1'b0;
			diag_q      <= '0;
			out_valid_q <= 1'b0;
			for (int a = 0; a < 3; a++) begin
				center_q[a] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_write_en) begin
				min_diag_q <= cfg_write_data;
			end
			if (do_clear) begin
				empty_q <= 1'b1;
				valid_q <= 1'b0;
				diag_q  <= '0;
				for (int a = 0; a < 3; a++) begin
					center_q[a] <= '0;
				end
			end else begin
				if (do_add) begin
					empty_q <= 1'b0;
				end
				if (do_eval) begin
					diag_q  <= DW'(root);
					valid_q <= CMPW'(root) > CMPW'(min_diag_q);
					for (int a = 0; a < 3; a++) begin
						center_q[a] <= csum[a][W:1];
					end
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// bounds and result payload carry no reset; empty_q masks the bounds
	always_ff @(posedge clk) begin
		if (accept) begin
			oth_q[0] <= other_x;
			oth_q[1] <= other_y;
			oth_q[2] <= other_z;
		end
		if (do_add) begin
			for (int a = 0; a < 3; a++) begin
				lo_q[a] <= nlo[a];
				up_q[a] <= nup[a];
			end
		end else if (do_ext) begin
			up_q[2] <= zsat;
		end
		if (out_load) begin
			for (int a = 0; a < 3; a++) begin
				out_lo_q[a]  <= empty_q ? '0 : lo_q[a];
				out_up_q[a]  <= empty_q ? '0 : up_q[a];
				out_ctr_q[a] <= center_q[a];
			end
			out_diag_q  <= diag_q;
			out_vres_q  <= valid_q;
			out_shape_q <= shape;
		end
	end

	aabb_sumsq #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_sumsq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_START),
		.lower  (lo_q),
		.upper  (up_q),
		.done   (sum_done),
		.sum    (sum)
	);

	aabb_isqrt #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    ((state_q == ST_SQ) && sum_done),
		.radicand (sum),
		.done     (rt_done),
		.root     (root)
	);

	assign out_valid   = out_valid_q;
	assign min_x       = out_lo_q[0];
	assign min_y       = out_lo_q[1];
	assign min_z       = out_lo_q[2];
	assign max_x       = out_up_q[0];
	assign max_y       = out_up_q[1];
	assign max_z       = out_up_q[2];
	assign center_x    = out_ctr_q[0];
	assign center_y    = out_ctr_q[1];
	assign center_z    = out_ctr_q[2];
	assign diagonal    = out_diag_q;
	assign valid_res   = out_vres_q;
	assign shape_class = out_shape_q;

	a_sum_done_in_sq: assert property (@(posedge clk) disable iff (!arst_n)
		sum_done |-> (state_q == ST_SQ))
		else $error("sum of squares finished outside its wait state");

	a_rt_done_in_rt: assert property (@(posedge clk) disable iff (!arst_n)
		rt_done |-> (state_q == ST_RT))
		else $error("square root finished outside its wait state");

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_OUT))
		else $error("result word appeared without the sequencer");

	a_valid_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> !empty_q)
		else $error("valid flag set on an empty box");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		do_clear |=> (empty_q && !valid_q && (diag_q == '0)))
		else $error("clear did not empty the box");

endmodule

`default_nettype wire

/* tb/tb_aabb_accumulator_3d.sv */
`timescale 1ns / 1ps

module tb_aabb_accumulator_3d;

	localparam int CW = aabb_pkg::COORD_WIDTH_DEF;

	typedef struct packed {
		aabb_pkg::opcode_t op;
		logic [CW-1:0] px, py, pz;
		logic [CW-1:0] ox, oy, oz;
		logic bv;
	} box_word_t;

	typedef struct packed {
		logic [CW-1:0] min_x, min_y, min_z;
		logic [CW-1:0] max_x, max_y, max_z;
		logic [CW-1:0] cx, cy, cz;
		logic [CW+1:0] diag;
		logic vld;
		aabb_pkg::shape_t shape;
	} box_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write_en = 1'b0;
	logic [aabb_pkg::CFG_WIDTH-1:0] cfg_write_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	aabb_pkg::opcode_t opcode = aabb_pkg::OP_CLEAR;
	logic [CW-1:0] point_x = '0, point_y = '0, point_z = '0;
	logic [CW-1:0] other_x = '0, other_y = '0, other_z = '0;
	logic box_valid = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [CW-1:0] min_x, min_y, min_z, max_x, max_y, max_z;
	logic [CW-1:0] center_x, center_y, center_z;
	logic [CW+1:0] diagonal;
	logic valid_res;
	aabb_pkg::shape_t shape_class;

	aabb_accumulator_3d dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.other_x(other_x), .other_y(other_y), .other_z(other_z),
		.box_valid(box_valid),
		.out_valid(out_valid), .out_stall(out_stall),
		.min_x(min_x), .min_y(min_y), .min_z(min_z),
		.max_x(max_x), .max_y(max_y), .max_z(max_z),
		.center_x(center_x), .center_y(center_y), .center_z(center_z),
		.diagonal(diagonal), .valid_res(valid_res), .shape_class(shape_class)
	);

	always #6 clk = ~clk;

	// box model state
	longint bb_lo[3], bb_hi[3], bb_mid[3];
	logic [CW+1:0] bb_diag = '0;
	bit bb_valid = 1'b0;
	bit bb_empty = 1'b1;
	logic [aabb_pkg::CFG_WIDTH-1:0] min_diag_model = '0;

	box_word_t pending_words[$];
	box_result_t box_results[$];
	box_word_t cur_word;
	int mismatches = 0;
	int results_seen = 0;
	bit calm = 1'b0;
	int unsigned hold_left = 0;
	bit hold_done = 1'b0;

	function automatic logic [CW+1:0] isqrt_floor(input logic [2*CW+1:0] s);
		logic [CW+1:0] root;
		logic [CW+1:0] trial;
		logic [2*CW+3:0] sq;
		root = '0;
		for (int b = CW + 1; b >= 0; b--) begin
			trial = root | ((CW+2)'(1) << b);
			sq = (2*CW+4)'(trial) * (2*CW+4)'(trial);
			if (sq <= (2*CW+4)'(s))
				root = trial;
		end
		return root;
	endfunction

	function automatic void grow_box(input longint x, input longint y, input longint z);
		longint p[3];
		p[0] = x; p[1] = y; p[2] = z;
		for (int a = 0; a < 3; a++) begin
			if (bb_empty || p[a] < bb_lo[a]) bb_lo[a] = p[a];
			if (bb_empty || p[a] > bb_hi[a]) bb_hi[a] = p[a];
		end
		bb_empty = 1'b0;
	endfunction

	function automatic void refresh_box();
		logic [2*CW+1:0] sq_sum;
		logic [2*CW+1:0] ext;
		longint d;
		sq_sum = '0;
		for (int a = 0; a < 3; a++) begin
			bb_mid[a] = (bb_hi[a] + bb_lo[a]) >>> 1;
			d = bb_hi[a] - bb_lo[a];
			if (d < 0) d = -d;
			ext = (2*CW+2)'(d);
			sq_sum = sq_sum + ext * ext;
		end
		bb_diag = isqrt_floor(sq_sum);
		bb_valid = bb_diag > (CW+2)'(min_diag_model);
	endfunction

	function automatic box_result_t advance_box(input box_word_t w);
		box_result_t r;
		longint zsum;
		int n_flat;
		case (w.op)
			aabb_pkg::OP_CLEAR: begin
				for (int a = 0; a < 3; a++) begin
					bb_lo[a] = 0; bb_hi[a] = 0; bb_mid[a] = 0;
				end
				bb_diag = '0;
				bb_valid = 1'b0;
				bb_empty = 1'b1;
			end
			aabb_pkg::OP_ADD_POINT: begin
				grow_box($signed(w.px), $signed(w.py), $signed(w.pz));
				refresh_box();
			end
			aabb_pkg::OP_ADD_BOX: begin
				if (w.bv) begin
					// max corner first, then min corner, no order check
					grow_box($signed(w.px), $signed(w.py), $signed(w.pz));
					grow_box($signed(w.ox), $signed(w.oy), $signed(w.oz));
					refresh_box();
				end
			end
			default: begin
				if (!bb_empty) begin
					zsum = bb_hi[2] + longint'($signed(w.pz));
					if (zsum > (longint'(1) << (CW-1)) - 1) zsum = (longint'(1) << (CW-1)) - 1;
					if (zsum < -(longint'(1) << (CW-1))) zsum = -(longint'(1) << (CW-1));
					bb_hi[2] = zsum;
					refresh_box();
				end
			end
		endcase
		n_flat = 0;
		for (int a = 0; a < 3; a++)
			if (bb_lo[a] == bb_hi[a]) n_flat++;
		r.min_x = bb_empty ? '0 : CW'(bb_lo[0]);
		r.min_y = bb_empty ? '0 : CW'(bb_lo[1]);
		r.min_z = bb_empty ? '0 : CW'(bb_lo[2]);
		r.max_x = bb_empty ? '0 : CW'(bb_hi[0]);
		r.max_y = bb_empty ? '0 : CW'(bb_hi[1]);
		r.max_z = bb_empty ? '0 : CW'(bb_hi[2]);
		r.cx = CW'(bb_mid[0]);
		r.cy = CW'(bb_mid[1]);
		r.cz = CW'(bb_mid[2]);
		r.diag = bb_diag;
		r.vld = bb_valid;
		if (bb_empty) r.shape = aabb_pkg::SHAPE_EMPTY;
		else if (n_flat == 3) r.shape = aabb_pkg::SHAPE_SINGLE;
		else if (n_flat > 0) r.shape = aabb_pkg::SHAPE_FLAT;
		else r.shape = aabb_pkg::SHAPE_SOLID;
		return r;
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				box_results.push_back(advance_box(cur_word));
			if (!in_valid || !in_stall) begin
				if (pending_words.size() != 0 && (calm || $urandom_range(99) >= 27)) begin
					cur_word = pending_words.pop_front();
					opcode <= cur_word.op;
					point_x <= cur_word.px;
					point_y <= cur_word.py;
					point_z <= cur_word.pz;
					other_x <= cur_word.ox;
					other_y <= cur_word.oy;
					other_z <= cur_word.oz;
					box_valid <= cur_word.bv;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [CW+1:0] want,
			input logic [CW+1:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		box_result_t want;
		box_result_t got;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				got = '{min_x, min_y, min_z, max_x, max_y, max_z,
					center_x, center_y, center_z, diagonal, valid_res, shape_class};
				if (box_results.size() == 0) begin
					$error("result word with no expectation pending");
					mismatches++;
				end else begin
					want = box_results.pop_front();
					check_field("min_x", want.min_x, got.min_x);
					check_field("min_y", want.min_y, got.min_y);
					check_field("min_z", want.min_z, got.min_z);
					check_field("max_x", want.max_x, got.max_x);
					check_field("max_y", want.max_y, got.max_y);
					check_field("max_z", want.max_z, got.max_z);
					check_field("center_x", want.cx, got.cx);
					check_field("center_y", want.cy, got.cy);
					check_field("center_z", want.cz, got.cz);
					check_field("diagonal", want.diag, got.diag);
					check_field("valid_res", want.vld, got.vld);
					check_field("shape_class", want.shape, got.shape);
				end
			end
			// one long hold-off so the block backs up into its input
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else if (!hold_done && results_seen >= 150) begin
				hold_done <= 1'b1;
				hold_left <= 800;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm && ($urandom_range(99) < 27);
			end
		end
	end

	function automatic box_word_t mk_word(input aabb_pkg::opcode_t op,
			input logic [CW-1:0] px, py, pz, ox, oy, oz, input logic bv);
		box_word_t w;
		w.op = op;
		w.px = px; w.py = py; w.pz = pz;
		w.ox = ox; w.oy = oy; w.oz = oz;
		w.bv = bv;
		return w;
	endfunction

	function automatic box_word_t noise_word(input aabb_pkg::opcode_t op);
		return mk_word(op, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom_range(1));
	endfunction

	function automatic logic [CW-1:0] pick_coord(input logic [CW-1:0] base,
			input int unsigned spread);
		case ($urandom_range(19))
			0: return {1'b0, {(CW-1){1'b1}}};
			1: return {1'b1, {(CW-1){1'b0}}};
			2: return $urandom;
			default: return base + CW'($urandom_range(2 * spread)) - CW'(spread);
		endcase
	endfunction

	task automatic drain();
		while (pending_words.size() != 0 || in_valid || box_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_min_diag(input logic [aabb_pkg::CFG_WIDTH-1:0] v);
		drain();
		repeat (4) @(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_write_data <= v;
		min_diag_model = v;
		@(posedge clk);
		cfg_write_en <= 1'b0;
	endtask

	// mostly well-formed runs around a cluster, some pure noise
	task automatic fill_random(input int n);
		logic [CW-1:0] base[3];
		logic [CW-1:0] amt;
		int unsigned spread;
		int len;
		int r;
		box_word_t w;
		while (n > 0) begin
			if ($urandom_range(99) < 12) begin
				pending_words.push_back(noise_word(aabb_pkg::opcode_t'($urandom_range(3))));
				n--;
			end else begin
				if ($urandom_range(3) != 0) begin
					pending_words.push_back(noise_word(aabb_pkg::OP_CLEAR));
					n--;
				end
				for (int a = 0; a < 3; a++)
					base[a] = ($urandom_range(2) == 0) ? CW'($urandom)
						: CW'($urandom_range(32'h40000)) - CW'(32'h20000);
				case ($urandom_range(4))
					0: spread = 16;
					1: spread = 32'h400;
					2: spread = 32'h4000;
					3: spread = 32'h8000;
					default: spread = 32'h10000;
				endcase
				len = $urandom_range(2, 10);
				for (int i = 0; i < len; i++) begin
					r = $urandom_range(99);
					w = noise_word(aabb_pkg::OP_ADD_POINT);
					w.px = pick_coord(base[0], spread);
					w.py = pick_coord(base[1], spread);
					w.pz = pick_coord(base[2], spread);
					if (r >= 45 && r < 75) begin
						w.op = aabb_pkg::OP_ADD_BOX;
						w.ox = pick_coord(base[0], spread);
						w.oy = pick_coord(base[1], spread);
						w.oz = pick_coord(base[2], spread);
						w.bv = $urandom_range(9) != 0;
					end else if (r >= 75) begin
						w.op = aabb_pkg::OP_EXTEND_Z;
						case ($urandom_range(9))
							0: amt = {1'b0, {(CW-1){1'b1}}};
							1: amt = {1'b1, {(CW-1){1'b0}}};
							2: amt = $urandom;
							default: amt = CW'($urandom_range(2 * spread)) - CW'(spread);
						endcase
						w.pz = amt;
					end
					pending_words.push_back(w);
					n--;
				end
			end
		end
	endtask

	initial begin
		localparam logic [CW-1:0] PMAX = {1'b0, {(CW-1){1'b1}}};
		localparam logic [CW-1:0] NMIN = {1'b1, {(CW-1){1'b0}}};
		localparam logic [CW-1:0] ONES = '1;
		for (int a = 0; a < 3; a++) begin
			bb_lo[a] = 0; bb_hi[a] = 0; bb_mid[a] = 0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		set_min_diag(16'd0);
		// extend and disabled box on an empty box are ignored
		pending_words.push_back(mk_word(aabb_pkg::OP_EXTEND_Z, 0, 0, 5, 0, 0, 0, 1'b1));
		pending_words.push_back(mk_word(aabb_pkg::OP_ADD_BOX, 9, 9, 9, 1, 1, 1, 1'b0));
		pending_words.push_back(mk_word(aabb_pkg::OP_ADD_POINT, 0, 0, 0,
			ONES, ONES, ONES, 1'b1));
		pending_words.push_back(mk_word(aabb_pkg::OP_ADD_POINT, 1, 1, 1, 0, 0, 0, 1'b0));
		pending_words.push_back(mk_word(aabb_pkg::OP_ADD_BOX, PMAX, PMAX, PMAX,
			NMIN, NMIN, NMIN, 1'b0));
		pending_words.push_back(mk_word(aabb_pkg::OP_ADD_POINT, PMAX, PMAX, PMAX,
			0, 0, 0, 1'b0));
		pending_words.push_back(mk_word(aabb_pkg::OP_ADD_POINT, NMIN, NMIN, NMIN,
			0, 0, 0, 1'b0));
		// saturate high, step down, then saturate low
		pending_words.push_back(mk_word(aabb_pkg::OP_EXTEND_Z, 0, 0, PMAX, 0, 0, 0, 1'b0));
		pending_words.push_back(mk_word(aabb_pkg::OP_EXTEND_Z, 0, 0, NMIN, 0, 0, 0, 1'b0));
		pending_words.push_back(mk_word(aabb_pkg::OP_EXTEND_Z, 0, 0, NMIN, 0, 0, 0, 1'b0));
		pending_words.push_back(mk_word(aabb_pkg::OP_CLEAR, ONES, ONES, ONES,
			ONES, ONES, ONES, 1'b1));
		pending_words.push_back(mk_word(aabb_pkg::OP_ADD_POINT, 32'h50000, 32'h50000,
			32'h50000, 0, 0, 0, 1'b0));
		pending_words.push_back(mk_word(aabb_pkg::OP_ADD_POINT, 32'h50000, 32'h50000,
			32'h60000, 0, 0, 0, 1'b0));
		// pull max z below min z
		pending_words.push_back(mk_word(aabb_pkg::OP_EXTEND_Z, 0, 0, -32'sh30000,
			0, 0, 0, 1'b0));
		pending_words.push_back(mk_word(aabb_pkg::OP_ADD_BOX, -32'sh10, -32'sh10, -32'sh10,
			32'h20, 32'h20, 32'h20, 1'b1));
		pending_words.push_back(mk_word(aabb_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 1'b0));
		pending_words.push_back(mk_word(aabb_pkg::OP_ADD_BOX, 3, 4, 5,
			-32'sd3, -32'sd4, -32'sd5, 1'b1));
		pending_words.push_back(mk_word(aabb_pkg::OP_ADD_POINT, ONES, ONES, ONES,
			0, 0, 0, 1'b1));
		pending_words.push_back(mk_word(aabb_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 1'b0));
		// odd negative sum: center rounds toward minus infinity
		pending_words.push_back(mk_word(aabb_pkg::OP_ADD_POINT, -32'sd3, 0, 7,
			0, 0, 0, 1'b0));
		pending_words.push_back(mk_word(aabb_pkg::OP_ADD_POINT, 0, 0, 0, 0, 0, 0, 1'b0));
		pending_words.push_back(mk_word(aabb_pkg::OP_ADD_POINT, 32'h8000, 32'h8000,
			32'h8000, 0, 0, 0, 1'b0));

		set_min_diag(16'hffff);
		fill_random(250);
		set_min_diag(16'd1);
		calm = 1'b1;
		fill_random(150);
		set_min_diag(16'($urandom_range(65535)));
		calm = 1'b0;
		fill_random(250);
		set_min_diag(16'h8000);
		fill_random(250);

		drain();
		repeat (60) @(posedge clk);
		if (mismatches == 0 && box_results.size() == 0)
			$display("tb_aabb_accumulator_3d OK");
		else
			$display("tb_aabb_accumulator_3d NOT OK");
		$finish;
	end

	initial begin
		#(10_000_000);
		$display("tb_aabb_accumulator_3d NOT OK");
		$finish;
	end

endmodule

/* sim.f */
design/aabb_pkg.sv
design/aabb_sumsq.sv
design/aabb_isqrt.sv
design/aabb_accumulator_3d.sv
tb/tb_aabb_accumulator_3d.sv
